@@ hdl/lds_pkg.sv @@
// Shared constants, codes and control types of the LOOK disk request scheduler.
package lds_pkg;

    localparam int MAX_REQUESTS  = 32;
    localparam int CYLINDER_BITS = 16;

    // Widths of the transaction fields.
    localparam int CYL_W  = 16;
    localparam int STEP_W = 16;
    localparam int TOT_W  = 22;

    // Stored cylinders keep only the bits that both the field and the drive have.
    localparam int STORE_W = (CYLINDER_BITS < CYL_W) ? CYLINDER_BITS : CYL_W;
    localparam int IDX_W   = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CNT_W   = $clog2(MAX_REQUESTS + 1);

    localparam logic [TOT_W-1:0] TOTAL_MAX = {TOT_W{1'b1}};

    // Configuration port.
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_HEAD  = 1'b0,
        CFG_SWEEP_RIGHT = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN,
        ST_FETCH1,
        ST_CALC1,
        ST_FETCH2,
        ST_CALC2
    } t_state;

    typedef struct packed {
        logic load;
        logic scan_init;
        logic scan;
        logic fetch_up;
        logic fetch_down;
        logic restart;
        logic calc;
        logic clear;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_hit;
        logic up_done;
        logic down_done;
        logic out_free;
    } t_dp_stat;

endpackage

@@ hdl/lds_req_if.sv @@
// Request channel: one disk cylinder request per transaction.
interface lds_req_if;
    import lds_pkg::*;

    logic             valid;
    logic             ready;
    logic [CYL_W-1:0] request_cylinder;
    logic             batch_end;

    modport source (output valid, output request_cylinder, output batch_end, input ready);
    modport sink   (input valid, input request_cylinder, input batch_end, output ready);
endinterface

@@ hdl/lds_res_if.sv @@
// Result channel: one served cylinder of the schedule per transaction.
interface lds_res_if;
    import lds_pkg::*;

    logic              valid;
    logic              ready;
    logic [CYL_W-1:0]  served_cylinder;
    logic [STEP_W-1:0] step_distance;
    logic [TOT_W-1:0]  total_movement;
    logic              last_served;

    modport source (
        output valid, output served_cylinder, output step_distance,
        output total_movement, output last_served, input ready
    );
    modport sink (
        input valid, input served_cylinder, input step_distance,
        input total_movement, input last_served, output ready
    );
endinterface

@@ hdl/lds_ctrl.sv @@
// Sequencer for loading, split search and the two sweeps of the LOOK order.
module lds_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_batch_end,
    input  logic               i_sweep_right,
    input  lds_pkg::t_dp_stat  i_stat,
    output logic               o_in_ready,
    output lds_pkg::t_dp_cmd   o_cmd
);
    import lds_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_batch_end) begin
                        o_cmd.scan_init = 1'b1;
                        n_state         = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_hit) begin
                    n_state = ST_FETCH1;
                end
            end
            ST_FETCH1: begin
                // The first sweep climbs from the split when it goes right.
                if (i_sweep_right) begin
                    if (i_stat.up_done) begin
                        o_cmd.restart = 1'b1;
                        n_state       = ST_FETCH2;
                    end else begin
                        o_cmd.fetch_up = 1'b1;
                        n_state        = ST_CALC1;
                    end
                end else begin
                    if (i_stat.down_done) begin
                        o_cmd.restart = 1'b1;
                        n_state       = ST_FETCH2;
                    end else begin
                        o_cmd.fetch_down = 1'b1;
                        n_state          = ST_CALC1;
                    end
                end
            end
            ST_CALC1: begin
                if (i_stat.out_free) begin
                    o_cmd.calc = 1'b1;
                    n_state    = ST_FETCH1;
                end
            end
            ST_FETCH2: begin
                if (i_sweep_right) begin
                    if (i_stat.down_done) begin
                        o_cmd.clear = 1'b1;
                        n_state     = ST_LOAD;
                    end else begin
                        o_cmd.fetch_down = 1'b1;
                        n_state          = ST_CALC2;
                    end
                end else begin
                    if (i_stat.up_done) begin
                        o_cmd.clear = 1'b1;
                        n_state     = ST_LOAD;
                    end else begin
                        o_cmd.fetch_up = 1'b1;
                        n_state        = ST_CALC2;
                    end
                end
            end
            ST_CALC2: begin
                if (i_stat.out_free) begin
                    o_cmd.calc = 1'b1;
                    n_state    = ST_FETCH2;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

endmodule

@@ hdl/lds_dp.sv @@
// Sorted request chain, split pointer, seek arithmetic and result register.
module lds_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [lds_pkg::CYL_W-1:0]    i_cyl,
    input  logic [lds_pkg::STORE_W-1:0]  i_start_head,
    input  lds_pkg::t_dp_cmd             i_cmd,
    output lds_pkg::t_dp_stat            o_stat,
    lds_res_if.source                    o_res
);
    import lds_pkg::*;

    logic [STORE_W-1:0] r_cell [MAX_REQUESTS];
    logic [STORE_W-1:0] n_cell [MAX_REQUESTS];
    logic [MAX_REQUESTS-1:0] w_gt;

    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_pos;
    logic [CNT_W-1:0]   r_split;
    logic [CNT_W-1:0]   r_served;
    logic [STORE_W-1:0] r_head;
    logic [STORE_W-1:0] r_cyl;
    logic [TOT_W-1:0]   r_total;

    logic               r_out_valid;
    logic [CYL_W-1:0]   r_out_cyl;
    logic [STEP_W-1:0]  r_out_step;
    logic [TOT_W-1:0]   r_out_total;
    logic               r_out_last;

    logic [STORE_W-1:0] w_new;
    logic               w_room;
    logic [CNT_W-1:0]   w_pos_dec;
    logic [IDX_W-1:0]   w_addr;
    logic [STORE_W-1:0] w_rd;
    logic [STORE_W-1:0] w_dist;
    logic [TOT_W:0]     w_sum;
    logic [TOT_W-1:0]   w_total;

    assign w_new  = i_cyl[STORE_W-1:0];
    assign w_room = (r_count < CNT_W'(MAX_REQUESTS));

    // Insertion into the sorted chain: every entry above the new value moves up one
    // place, and the new value lands in the first place whose entry is larger.
    always_comb begin
        for (int i = 0; i < MAX_REQUESTS; i++) begin
            w_gt[i] = (CNT_W'(i) >= r_count) || (r_cell[i] > w_new);
        end
        for (int i = 0; i < MAX_REQUESTS; i++) begin
            if (i > 0 && w_gt[(i > 0) ? i - 1 : 0]) begin
                n_cell[i] = r_cell[(i > 0) ? i - 1 : 0];
            end else if (w_gt[i]) begin
                n_cell[i] = w_new;
            end else begin
                n_cell[i] = r_cell[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_room) begin
            r_cell <= n_cell;
        end
    end

    // One read port serves the split search and both sweeps.
    assign w_pos_dec = r_pos - 1'b1;
    assign w_addr    = i_cmd.fetch_down ? w_pos_dec[IDX_W-1:0] : r_pos[IDX_W-1:0];
    assign w_rd      = r_cell[w_addr];

    assign o_stat.up_done   = (r_pos >= r_count);
    assign o_stat.down_done = (r_pos == '0);
    assign o_stat.scan_hit  = (r_pos >= r_count) || (w_rd >= r_head);
    assign o_stat.out_free  = !r_out_valid || o_res.ready;

    assign w_dist  = (r_cyl >= r_head) ? (r_cyl - r_head) : (r_head - r_cyl);
    assign w_sum   = {1'b0, r_total} + (TOT_W + 1)'(w_dist);
    assign w_total = w_sum[TOT_W] ? TOTAL_MAX : w_sum[TOT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_count <= '0;
            end else if (i_cmd.load && w_room) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.calc) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_pos <= '0;
        end else if (i_cmd.scan && !o_stat.scan_hit) begin
            r_pos <= r_pos + 1'b1;
        end else if (i_cmd.fetch_up) begin
            r_pos <= r_pos + 1'b1;
        end else if (i_cmd.fetch_down) begin
            r_pos <= w_pos_dec;
        end else if (i_cmd.restart) begin
            r_pos <= r_split;
        end

        if (i_cmd.scan && o_stat.scan_hit) begin
            r_split <= r_pos;
        end

        if (i_cmd.fetch_up || i_cmd.fetch_down) begin
            r_cyl <= w_rd;
        end

        if (i_cmd.scan_init) begin
            r_head   <= i_start_head;
            r_total  <= '0;
            r_served <= '0;
        end else if (i_cmd.calc) begin
            r_head   <= r_cyl;
            r_total  <= w_total;
            r_served <= r_served + 1'b1;
        end

        if (i_cmd.calc) begin
            r_out_cyl   <= CYL_W'(r_cyl);
            r_out_step  <= STEP_W'(w_dist);
            r_out_total <= w_total;
            r_out_last  <= ((r_served + 1'b1) == r_count);
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.served_cylinder = r_out_cyl;
    assign o_res.step_distance   = r_out_step;
    assign o_res.total_movement  = r_out_total;
    assign o_res.last_served     = r_out_last;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_REQUESTS))
        else $error("request count exceeds the store depth");

    a_calc_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.calc |-> o_stat.out_free)
        else $error("result computed while the previous one is still pending");

    a_calc_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.calc |=> r_out_valid)
        else $error("computed result was not presented");

    a_fetch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_cmd.fetch_up || (r_pos < r_count)) && (!i_cmd.fetch_down || (r_pos != '0)))
        else $error("sweep read outside the stored requests");
`endif

endmodule

@@ hdl/look_disk_request_scheduler_top.sv @@
// Top level of the LOOK disk request scheduler: configuration registers and core.
//
//   channel   dir   handshake        payload
//   i_req     in    valid / ready    request_cylinder, batch_end
//   o_res     out   valid / ready    served_cylinder, step_distance, total_movement,
//                                    last_served
//   config    in    i_cfg_we         i_cfg_index, i_cfg_wdata
//
// Each request is inserted into the sorted chain of 32 registers as it is taken.
// After the batch-end transaction, the split search walks the chain through its one
// read port, then each result takes a read step and a seek arithmetic step, with a
// restart at the split at the sweep turn and a clear at the end of a batch.
// A result waiting in the output register stalls only the next seek computation.
// Reset is synchronous and needs no clearing pass.
module look_disk_request_scheduler_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    lds_req_if.sink                         i_req,
    lds_res_if.source                       o_res,
    input  logic                            i_cfg_we,
    input  logic [lds_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lds_pkg::CFG_W-1:0]       i_cfg_wdata
);
    import lds_pkg::*;

    logic [STORE_W-1:0] r_start_head;
    logic               r_sweep_right;
    logic               w_in_ready;
    t_dp_cmd            w_cmd;
    t_dp_stat           w_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_head  <= '0;
            r_sweep_right <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_START_HEAD:  r_start_head  <= i_cfg_wdata[STORE_W-1:0];
                CFG_SWEEP_RIGHT: r_sweep_right <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    assign i_req.ready = w_in_ready;

    lds_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_req.valid),
        .i_batch_end   (i_req.batch_end),
        .i_sweep_right (r_sweep_right),
        .i_stat        (w_stat),
        .o_in_ready    (w_in_ready),
        .o_cmd         (w_cmd)
    );

    lds_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cyl        (i_req.request_cylinder),
        .i_start_head (r_start_head),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_res        (o_res)
    );

endmodule
